FILE: hw/rtl/rhv_pkg.sv
// ----------------------------------------------------------------------------
// rhv_pkg
// Shared types and constants for the video-range RGB to HSV converter.
// ----------------------------------------------------------------------------
package rhv_pkg;

  localparam int ChanW     = 8;
  localparam int NumW      = 16;
  localparam int HueNumW   = 14;
  localparam int QuoW      = 8;
  localparam int HueW      = 9;
  localparam int LowLimit  = 16;
  localparam int HighLimit = 240;
  localparam int GreenBase = 120;
  localparam int BlueBase  = 240;
  localparam int FullTurn  = 360;

  localparam logic [1:0] REG_INPUT_FORMAT = 2'd0;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    logic             oor;
    logic             dz;
    sector_t          sector;
    logic             neg;
    logic [ChanW-1:0] mx;
  } side_t;

  typedef struct packed {
    side_t              side;
    logic [NumW-1:0]    sat_num;
    logic [HueNumW-1:0] hue_num;
    logic [ChanW-1:0]   delta;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

FILE: hw/rtl/rhv_front.sv
// ----------------------------------------------------------------------------
// rhv_front
// Classifies a pixel: range check, offset removal, max/min, sector and the
// dividends for the saturation and hue quotients.
// ----------------------------------------------------------------------------
module rhv_front (
  input  logic                fmt,
  input  logic [23:0]         pix,
  output rhv_pkg::item_t      item
);
  import rhv_pkg::*;

  function automatic logic [ChanW-1:0] prep(input logic [ChanW-1:0] c, input logic f);
    prep = f ? {c[4:0], 3'b000} : c;
  endfunction

  function automatic logic bad(input logic [ChanW-1:0] c);
    bad = (c < ChanW'(LowLimit)) || (c > ChanW'(HighLimit));
  endfunction

  logic [ChanW-1:0] r, g, b;
  logic [ChanW-1:0] rs, gs, bs;
  logic [ChanW-1:0] mx, mn, delta, dabs;
  logic             neg;
  sector_t          sector;

  assign r  = prep(pix[7:0], fmt);
  assign g  = prep(pix[15:8], fmt);
  assign b  = prep(pix[23:16], fmt);
  assign rs = r - ChanW'(LowLimit);
  assign gs = g - ChanW'(LowLimit);
  assign bs = b - ChanW'(LowLimit);

  always_comb begin
    mn = rs;
    if (gs < mn) mn = gs;
    if (bs < mn) mn = bs;
    if (rs >= gs && rs >= bs) begin
      sector = SEC_RED;
      mx     = rs;
      neg    = gs < bs;
      dabs   = neg ? (bs - gs) : (gs - bs);
    end else if (gs >= bs) begin
      sector = SEC_GREEN;
      mx     = gs;
      neg    = bs < rs;
      dabs   = neg ? (rs - bs) : (bs - rs);
    end else begin
      sector = SEC_BLUE;
      mx     = bs;
      neg    = rs < gs;
      dabs   = neg ? (gs - rs) : (rs - gs);
    end
  end

  assign delta = mx - mn;

  assign item.side.oor    = bad(r) || bad(g) || bad(b);
  assign item.side.dz     = (delta == '0);
  assign item.side.sector = sector;
  assign item.side.neg    = neg;
  assign item.side.mx     = mx;
  // 224*delta and 60*|diff| as shift-and-subtract
  assign item.sat_num = {delta, 8'b0} - {3'b0, delta, 5'b0};
  assign item.hue_num = {dabs, 6'b0} - {4'b0, dabs, 2'b0};
  assign item.delta   = delta;

endmodule

FILE: hw/rtl/rhv_fifo.sv
// ----------------------------------------------------------------------------
// rhv_fifo
// Short queue between the classifier and the divider pipeline.
// ----------------------------------------------------------------------------
module rhv_fifo #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 pop,
  output logic [WIDTH-1:0]     rdata,
  output rhv_pkg::fifo_stat_t  stat
);
  import rhv_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata      = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == (AW + 1)'(DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

FILE: hw/rtl/rhv_div.sv
// ----------------------------------------------------------------------------
// rhv_div
// Pipelined restoring divider, one quotient bit per stage. The caller
// guarantees the quotient fits in QuoW bits.
// ----------------------------------------------------------------------------
module rhv_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [rhv_pkg::NumW-1:0]  num,
  input  logic [rhv_pkg::ChanW-1:0] den,
  output logic [rhv_pkg::QuoW-1:0]  quo
);
  import rhv_pkg::*;

  logic [NumW-1:0]  rem_r [QuoW-1];
  logic [ChanW-1:0] den_r [QuoW-1];
  logic [QuoW-1:0]  quo_r [QuoW];

  genvar s;
  for (s = 0; s < QuoW; s++) begin : g_stage
    logic [NumW-1:0]  rem_in, trial;
    logic [ChanW-1:0] den_in;
    logic [QuoW-1:0]  quo_in, quo_nxt;
    logic             take;

    if (s == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    assign trial = NumW'(den_in) << (QuoW - 1 - s);
    assign take  = (rem_in >= trial);

    always_comb begin
      quo_nxt               = quo_in;
      quo_nxt[QuoW - 1 - s] = take;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[s] <= quo_nxt;
      end
    end

    if (s < QuoW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= take ? (rem_in - trial) : rem_in;
          den_r[s] <= den_in;
        end
      end
    end
  end

  assign quo = quo_r[QuoW-1];

endmodule

FILE: hw/rtl/rhv_back.sv
// ----------------------------------------------------------------------------
// rhv_back
// Divider pipeline for saturation and hue, hue assembly and output register.
// ----------------------------------------------------------------------------
module rhv_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rhv_pkg::item_t               item,
  input  rhv_pkg::fifo_stat_t          stat,
  output logic                         pop,
  input  logic                         ready,
  output logic                         valid,
  output logic [rhv_pkg::HueW-1:0]     hue,
  output logic [rhv_pkg::ChanW-1:0]    sat,
  output logic [rhv_pkg::ChanW-1:0]    bright,
  output logic                         oor
);
  import rhv_pkg::*;

  logic                adv;
  logic                vld_r [QuoW];
  side_t               side_r [QuoW];
  logic [QuoW-1:0]     quo_s, quo_h;
  side_t               last;
  logic [HueW-1:0]     hue_nxt;
  logic [ChanW-1:0]    sat_nxt, bright_nxt;
  logic                out_vld_r;
  logic [HueW-1:0]     hue_r;
  logic [ChanW-1:0]    sat_r, bright_r;
  logic                oor_r;

  assign adv = !out_vld_r || ready;
  assign pop = adv && !stat.empty;

  rhv_div u_div_sat (
    .clk (clk),
    .en  (adv),
    .num (item.sat_num),
    .den (item.side.mx),
    .quo (quo_s)
  );

  rhv_div u_div_hue (
    .clk (clk),
    .en  (adv),
    .num (NumW'(item.hue_num)),
    .den (item.delta),
    .quo (quo_h)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QuoW; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= pop;
      for (int i = 1; i < QuoW; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= item.side;
      for (int i = 1; i < QuoW; i++) side_r[i] <= side_r[i-1];
    end
  end

  assign last = side_r[QuoW-1];

  always_comb begin
    hue_nxt    = '0;
    sat_nxt    = '0;
    bright_nxt = '0;
    if (!last.oor) begin
      bright_nxt = last.mx;
      if (!last.dz) begin
        sat_nxt = quo_s;
        case (last.sector)
          SEC_RED: begin
            hue_nxt = (last.neg && quo_h != '0) ?
                      HueW'(FullTurn) - HueW'(quo_h) : HueW'(quo_h);
          end
          SEC_GREEN: begin
            hue_nxt = last.neg ? HueW'(GreenBase) - HueW'(quo_h)
                               : HueW'(GreenBase) + HueW'(quo_h);
          end
          default: begin
            hue_nxt = last.neg ? HueW'(BlueBase) - HueW'(quo_h)
                               : HueW'(BlueBase) + HueW'(quo_h);
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= vld_r[QuoW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hue_r    <= hue_nxt;
      sat_r    <= sat_nxt;
      bright_r <= bright_nxt;
      oor_r    <= last.oor;
    end
  end

  assign valid  = out_vld_r;
  assign hue    = hue_r;
  assign sat    = sat_r;
  assign bright = bright_r;
  assign oor    = oor_r;

endmodule

FILE: hw/rtl/rgb_to_hsv_video_range.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_video_range
// Integer RGB to HSV conversion for video-range pixels.
// ----------------------------------------------------------------------------
// Input words carry one pixel (red, green, blue). Output words carry hue
// (0..359), saturation (0..224), brightness (max channel - 16) and, in
// tuser, an out-of-range flag; an out-of-range pixel gives all zero values.
// One word in gives one word out, in order.
// The input_format register (byte address 0) selects 8-bit channels (0) or
// 5-bit channels shifted left by three (1); write it only while idle.
// From input acceptance to out_tvalid a word passes the queue write, eight
// stages of the pipelined dividers (one quotient bit each) and the output
// register. Throughput is one word per cycle while the receiver takes every
// output word; the two dividers are fully pipelined.
// A stalled receiver freezes the divider pipeline; the queue
// keeps taking words until its FIFO_DEPTH entries are full, then
// in_tready drops.
// Reset clears the queue, the pipeline valid bits and input_format.
// ----------------------------------------------------------------------------
module rgb_to_hsv_video_range #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // red[7:0], green[15:8], blue[23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // hue[8:0], saturation[16:9], brightness[24:17]
  output logic [0:0]  out_tuser,   // out_of_range[0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import rhv_pkg::*;

  logic             fmt_r;
  logic             cfg_wr;
  item_t            item_in, item_q;
  fifo_stat_t       stat;
  logic             push, pop;
  logic [HueW-1:0]  hue;
  logic [ChanW-1:0] sat, bright;
  logic             oor;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= 1'b0;
    end else if (cfg_wr && cfg_paddr == REG_INPUT_FORMAT) begin
      fmt_r <= cfg_pwdata[0];
    end
  end

  assign cfg_prdata = (cfg_paddr == REG_INPUT_FORMAT) ? {31'b0, fmt_r} : '0;

  rhv_front u_front (
    .fmt  (fmt_r),
    .pix  (in_tdata),
    .item (item_in)
  );

  assign in_tready = !stat.full;
  assign push      = in_tvalid && in_tready;

  rhv_fifo #(
    .DEPTH (FIFO_DEPTH),
    .WIDTH ($bits(item_t))
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (item_in),
    .pop   (pop),
    .rdata (item_q),
    .stat  (stat)
  );

  rhv_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (item_q),
    .stat   (stat),
    .pop    (pop),
    .ready  (out_tready),
    .valid  (out_tvalid),
    .hue    (hue),
    .sat    (sat),
    .bright (bright),
    .oor    (oor)
  );

  assign out_tdata = {7'b0, bright, sat, hue};
  assign out_tuser = oor;

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[24:0] == '0)
    else $error("out-of-range word with nonzero fields");

  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> hue < HueW'(FullTurn) && sat <= 8'd224 && bright <= 8'd224)
    else $error("output field out of range");

  a_sat_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && sat != '0 |-> bright != '0)
    else $error("saturation without brightness");

  a_queue: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !stat.empty)
    else $error("accepted word missing from queue");

endmodule

FILE: verif/rgb_to_hsv_video_range_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_video_range_test
// Self-checking bench for the video-range RGB to HSV converter.
// ----------------------------------------------------------------------------
// Pixels go in over the input stream. Each accepted word is converted by a
// local model into the HSV word it should produce, and that word is queued.
// Output words are compared field by field against the queue head. Coverage
// comes from a directed set of corner pixels in both input formats, random
// pixels under bursty input and a stalling receiver, and one long receiver
// hold that backs the block up. The format register is written and read
// back between phases while the block is idle.
// ----------------------------------------------------------------------------
module rgb_to_hsv_video_range_test;
  import rhv_pkg::*;

  localparam int ClkPeriod  = 12;
  localparam int SatScale   = 224;
  localparam int SectorSpan = 60;
  localparam int DrainWait  = 16;

  typedef struct packed {
    logic [8:0] hue;
    logic [7:0] sat;
    logic [7:0] bright;
    logic       oor;
  } hsv_t;

  typedef enum int {
    SINK_ALWAYS,
    SINK_RANDOM,
    SINK_PATTERN
  } sink_mode_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;    // red[7:0], green[15:8], blue[23:16]
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;   // hue[8:0], saturation[16:9], brightness[24:17]
  logic [0:0]  out_tuser;   // out_of_range[0]
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [1:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  hsv_t       hsv_expected_q[$];
  logic       input_format;
  int         error_count;
  int         burst_left;
  bit         sender_gaps;
  sink_mode_t sink_mode;
  logic [15:0] sink_pattern;
  int         hold_request;

  rgb_to_hsv_video_range i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  function automatic hsv_t hsv_of_pixel(logic [7:0] r_raw, logic [7:0] g_raw,
                                        logic [7:0] b_raw, logic fmt);
    hsv_t       res;
    logic [7:0] r, g, b;
    int         ri, gi, bi, mx, mn, delta, sat, hue;
    res = '0;
    r = fmt ? {r_raw[4:0], 3'b000} : r_raw;
    g = fmt ? {g_raw[4:0], 3'b000} : g_raw;
    b = fmt ? {b_raw[4:0], 3'b000} : b_raw;
    if (r < LowLimit || r > HighLimit || g < LowLimit || g > HighLimit ||
        b < LowLimit || b > HighLimit) begin
      res.oor = 1'b1;
      return res;
    end
    ri = int'(r) - LowLimit;
    gi = int'(g) - LowLimit;
    bi = int'(b) - LowLimit;
    mx = ri;
    if (gi > mx) mx = gi;
    if (bi > mx) mx = bi;
    mn = ri;
    if (gi < mn) mn = gi;
    if (bi < mn) mn = bi;
    delta = mx - mn;
    sat = (mx != 0) ? (SatScale * delta) / mx : 0;
    // integer division truncates toward zero, as the block does
    if (sat == 0 || delta == 0) begin
      hue = 0;
    end else if (ri == mx) begin
      hue = (SectorSpan * (gi - bi)) / delta;
      if (hue < 0) hue += FullTurn;
    end else if (gi == mx) begin
      hue = GreenBase + (SectorSpan * (bi - ri)) / delta;
    end else begin
      hue = BlueBase + (SectorSpan * (ri - gi)) / delta;
    end
    res.hue    = hue[8:0];
    res.sat    = sat[7:0];
    res.bright = mx[7:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // one pixel, held until accepted; expectation queued at acceptance
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    in_tvalid <= 1'b1;
    in_tdata  <= {b, g, r};
    do @(posedge clk); while (!in_tready);
    hsv_expected_q.push_back(hsv_of_pixel(r, g, b, input_format));
  endtask

  task automatic pace_sender();
    if (sender_gaps && burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
  endtask

  task automatic wait_idle();
    while (hsv_expected_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_format(logic [31:0] value);
    logic readback;
    in_tvalid <= 1'b0;
    wait_idle();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 2'(4 * REG_INPUT_FORMAT);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    input_format = value[0];
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    readback = cfg_prdata[0];
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (readback !== input_format)
      report_mismatch("input_format readback", readback, input_format);
    @(posedge clk);
  endtask

  function automatic logic [7:0] random_channel();
    if (!input_format && $urandom_range(0, 4) != 0)
      return 8'($urandom_range(LowLimit, HighLimit));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_random_pixels(int count);
    logic [7:0] r, g, b;
    for (int i = 0; i < count; i++) begin
      pace_sender();
      r = random_channel();
      g = random_channel();
      b = random_channel();
      case ($urandom_range(0, 19))
        0:       begin g = r; b = r; end   // gray
        1:       g = r;                    // red/green tie
        2:       b = g;
        default: ;
      endcase
      send_pixel(r, g, b);
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed_8bit();
    sink_mode   = SINK_ALWAYS;
    sender_gaps = 1'b0;
    write_format(32'hFFFF_FFFE);         // upper bits ignored
    send_pixel(8'd16, 8'd16, 8'd16);     // black, zero value
    send_pixel(8'd240, 8'd240, 8'd240);  // white, unsaturated
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd15, 8'd100, 8'd100);   // below range
    send_pixel(8'd100, 8'd241, 8'd100);  // above range
    send_pixel(8'd100, 8'd100, 8'd0);
    send_pixel(8'd240, 8'd128, 8'd16);   // red sector
    send_pixel(8'd240, 8'd16, 8'd128);   // red sector, wrapped
    send_pixel(8'd16, 8'd240, 8'd128);   // green sector
    send_pixel(8'd128, 8'd16, 8'd240);   // blue sector
    send_pixel(8'd240, 8'd240, 8'd16);   // red wins over green
    send_pixel(8'd240, 8'd16, 8'd240);   // red wins over blue
    send_pixel(8'd16, 8'd240, 8'd240);   // green wins over blue
    send_pixel(8'd17, 8'd16, 8'd16);     // smallest value
    send_pixel(8'd240, 8'd239, 8'd239);  // smallest saturation
    send_pixel(8'd200, 8'd17, 8'd16);    // truncation
    send_pixel(8'd57, 8'd200, 8'd131);
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_random_8bit();
    sink_mode   = SINK_RANDOM;
    sender_gaps = 1'b1;
    send_random_pixels(140);
    sink_mode = SINK_PATTERN;
    send_random_pixels(140);
  endtask

  task automatic test_directed_5bit();
    sink_mode   = SINK_ALWAYS;
    sender_gaps = 1'b0;
    write_format(32'h0000_0001);
    send_pixel(8'd2, 8'd2, 8'd2);        // black
    send_pixel(8'd30, 8'd30, 8'd30);     // white
    send_pixel(8'd1, 8'd10, 8'd10);      // below range
    send_pixel(8'd10, 8'd31, 8'd10);     // above range
    send_pixel(8'hE2, 8'hFE, 8'h8F);     // upper bits dropped
    send_pixel(8'd30, 8'd2, 8'd16);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_random_5bit();
    sink_mode   = SINK_RANDOM;
    sender_gaps = 1'b1;
    send_random_pixels(90);
    sink_mode   = SINK_ALWAYS;
    sender_gaps = 1'b0;
    send_random_pixels(90);
  endtask

  task automatic test_backpressure();
    write_format(32'h0000_0000);
    sink_mode    = SINK_ALWAYS;
    sender_gaps  = 1'b0;
    hold_request = 60;
    send_random_pixels(48);
  endtask

  task automatic test_format_switching();
    sink_mode   = SINK_PATTERN;
    sender_gaps = 1'b1;
    write_format(32'h0000_0001);
    send_random_pixels(60);
    write_format(32'hFFFF_FFFE);
    send_random_pixels(60);
  endtask

  // receiver: long hold on request, else stall per current mode
  initial begin
    int hold_len;
    int cycle;
    out_tready   <= 1'b0;
    hold_request = 0;
    sink_mode    = SINK_ALWAYS;
    sink_pattern = 16'($urandom());
    cycle        = 0;
    forever begin
      @(posedge clk);
      cycle++;
      if (hold_request > 0) begin
        hold_len     = hold_request;
        hold_request = 0;
        out_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
      end
      case (sink_mode)
        SINK_RANDOM:  out_tready <= ($urandom_range(0, 3) != 0);
        SINK_PATTERN: out_tready <= sink_pattern[cycle % 16] | (cycle % 64 < 8);
        default:      out_tready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    hsv_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (hsv_expected_q.size() == 0) begin
        report_mismatch("unexpected word, queue depth", 1, 0);
      end else begin
        want = hsv_expected_q.pop_front();
        if (out_tdata[8:0] !== want.hue)
          report_mismatch("hue", out_tdata[8:0], want.hue);
        if (out_tdata[16:9] !== want.sat)
          report_mismatch("saturation", out_tdata[16:9], want.sat);
        if (out_tdata[24:17] !== want.bright)
          report_mismatch("brightness", out_tdata[24:17], want.bright);
        if (out_tuser[0] !== want.oor)
          report_mismatch("out_of_range", out_tuser[0], want.oor);
        if (out_tdata[31:25] !== 7'd0)
          report_mismatch("tdata padding", out_tdata[31:25], 0);
      end
    end
  end

  initial begin
    #(ClkPeriod * 200000);
    $display("rgb_to_hsv_video_range_test: errors");
    $finish;
  end

  initial begin
    error_count  = 0;
    burst_left   = 0;
    sender_gaps  = 1'b0;
    input_format = 1'b0;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_8bit();
    test_random_8bit();
    test_directed_5bit();
    test_random_5bit();
    test_backpressure();
    test_format_switching();

    sink_mode = SINK_ALWAYS;
    wait_idle();
    if (error_count == 0) begin
      $display("rgb_to_hsv_video_range_test: clean");
    end else begin
      $display("rgb_to_hsv_video_range_test: errors");
    end
    $finish;
  end

endmodule
